// ===== sv/rrw_pkg.sv =====
// rrw_pkg: shared types and constants of the reorder receive window
// used by rrw_alu and reorder_receive_window; no dependencies
`default_nettype none

package rrw_pkg;

    localparam int DEF_WINDOW      = 16;
    localparam int DEF_MAX_PAYLOAD = 1472;
    localparam int MAX_REL         = 16;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 5;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIV = 2'd2;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_ACK_MODE    = 1'b1;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== sv/rrw_ram.sv =====
// rrw_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/rrw_alu.sv =====
// rrw_alu: shared 32-bit adder/subtractor with carry-borrow out
// depends on rrw_pkg
`default_nettype none

module rrw_alu (
    input  wire rrw_pkg::alu_req_t    req,
    output logic [rrw_pkg::SEQ_W:0]   res
);

    import rrw_pkg::*;

    always_comb begin
        case (req.op)
            ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
            default: res = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/reorder_receive_window.sv =====
// reorder_receive_window: sliding-window receiver with reorder ring and sequencer
// depends on rrw_pkg, rrw_alu, rrw_ram
//
// channel   dir  tdata fields (low bit up)                      tuser  tlast
// s_        in   seq_num, pkt_length, buffer_tag                 -      -
// m_        out  seq_value, out_length, out_tag, total_bytes     kind   last
// cfg_      in   write enable, register index, write data        -      -
//
// dropped or early packet: check, then head until the result is taken
// in-order packet releasing n slots: check, scan, sum, head; read, calc, out per slot
// one packet at a time; s_tready only while idle, each result waits for m_tready
// the shared adder/subtractor sets the pace: compare, ack number, byte total, next expected
// valid bits clear at reset, no clearing pass
`default_nettype none

module reorder_receive_window #(
    parameter int WINDOW      = rrw_pkg::DEF_WINDOW,
    parameter int MAX_PAYLOAD = rrw_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // seq_num[31:0], pkt_length[42:32], buffer_tag[58:43], zero fill
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // seq_value[31:0], out_length[42:32], out_tag[58:43], total_bytes[90:59], zero fill
    output logic      [95:0] m_tdata,
    // kind[1:0]
    output logic [rrw_pkg::KIND_W-1:0] m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [rrw_pkg::CFG_W-1:0] cfg_wdata
);

    import rrw_pkg::*;

    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = IDX_W + 1;
    localparam int EW_CAP  = (WINDOW < 16) ? WINDOW : 16;
    localparam int REL_CAP = (WINDOW < MAX_REL) ? WINDOW : MAX_REL;
    localparam int CNT_W   = $clog2(MAX_REL + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_CHECK = 8'b00000010,
        ST_SCAN  = 8'b00000100,
        ST_SUM   = 8'b00001000,
        ST_HEAD  = 8'b00010000,
        ST_RD    = 8'b00100000,
        ST_CALC  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  window_size_reg;
    logic              ack_mode_reg;
    logic [CFG_W-1:0]  ew;

    logic [SEQ_W-1:0]  seq_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [LEN_W-1:0]  len_sat;

    logic [SEQ_W-1:0]  exp_reg, exp_next;
    logic [IDX_W-1:0]  exp_idx_reg, exp_idx_next;
    logic [SEQ_W-1:0]  total_reg, total_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              mvalid_reg, mvalid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SEQ_W-1:0]  oseq_reg, oseq_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [TAG_W-1:0]  otag_reg, otag_next;
    logic [SEQ_W-1:0]  ototal_reg, ototal_next;
    logic              olast_reg, olast_next;

    alu_req_t          alu_req;
    logic [SEQ_W:0]    alu_res;

    logic                   ram_we;
    logic [IDX_W-1:0]       slot;
    logic [SUM_W-1:0]       slot_sum;
    logic [SUM_W-1:0]       d_ext;
    logic [LEN_W+TAG_W-1:0] ram_rdata;
    logic [LEN_W-1:0]       rd_len;
    logic [TAG_W-1:0]       rd_tag;
    logic                   below;
    logic                   beyond;
    logic                   s_xfer;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(WINDOW - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    rrw_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    rrw_ram #(
        .WIDTH (LEN_W + TAG_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot),
        .wdata ({tag_reg, len_reg}),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign rd_len = ram_rdata[LEN_W-1:0];
    assign rd_tag = ram_rdata[LEN_W+TAG_W-1:LEN_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'd0, ototal_reg, otag_reg, olen_reg, oseq_reg};

    assign ew = (window_size_reg > CFG_W'(EW_CAP)) ? CFG_W'(EW_CAP) : window_size_reg;
    assign len_sat = (s_tdata[42:32] > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                           : s_tdata[42:32];

    // ring slot of an in-window packet
    assign d_ext    = SUM_W'(alu_res[4:0]);
    assign slot_sum = SUM_W'(exp_idx_reg) + d_ext;
    assign slot     = (slot_sum >= SUM_W'(WINDOW)) ? IDX_W'(slot_sum - SUM_W'(WINDOW))
                                                   : IDX_W'(slot_sum);

    assign below  = alu_res[SEQ_W];
    assign beyond = !below && ((|alu_res[SEQ_W-1:5]) || (alu_res[4:0] >= ew));

    // operands of the shared unit per sequencer step
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = exp_reg;
        alu_req.b  = SEQ_W'(1);
        case (state_reg)
            ST_CHECK: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = seq_reg;
                alu_req.b  = exp_reg;
            end
            ST_SUM: begin
                alu_req.b = SEQ_W'(cnt_reg);
            end
            ST_CALC: begin
                alu_req.a = total_reg;
                alu_req.b = SEQ_W'(rd_len);
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        exp_idx_next = exp_idx_reg;
        total_next   = total_reg;
        valid_next   = valid_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        mvalid_next  = mvalid_reg;
        kind_next    = kind_reg;
        oseq_next    = oseq_reg;
        olen_next    = olen_reg;
        otag_next    = otag_reg;
        ototal_next  = ototal_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                olen_next   = '0;
                otag_next   = '0;
                ototal_next = total_reg;
                if (below || beyond) begin
                    kind_next   = (below && ack_mode_reg) ? KIND_ACK : KIND_DROP;
                    oseq_next   = seq_reg;
                    olast_next  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_HEAD;
                end else begin
                    ram_we           = 1'b1;
                    valid_next[slot] = 1'b1;
                    if (alu_res[SEQ_W-1:0] == '0) begin
                        ptr_next   = exp_idx_reg;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        kind_next   = KIND_ACK;
                        oseq_next   = ack_mode_reg ? seq_reg : exp_reg;
                        olast_next  = 1'b1;
                        mvalid_next = 1'b1;
                        state_next  = ST_HEAD;
                    end
                end
            end
            ST_SCAN: begin
                // length of the run of filled slots from the expected one, capped at REL_CAP
                if (valid_reg[ptr_reg] && (cnt_reg < CNT_W'(REL_CAP))) begin
                    cnt_next = cnt_reg + 1'b1;
                    ptr_next = next_idx(ptr_reg);
                end else begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                kind_next   = KIND_ACK;
                oseq_next   = ack_mode_reg ? seq_reg : alu_res[SEQ_W-1:0];
                olast_next  = 1'b0;
                mvalid_next = 1'b1;
                ptr_next    = exp_idx_reg;
                state_next  = ST_HEAD;
            end
            ST_HEAD: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = olast_reg ? ST_IDLE : ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                total_next          = alu_res[SEQ_W-1:0];
                kind_next           = KIND_DELIV;
                oseq_next           = exp_reg;
                olen_next           = rd_len;
                otag_next           = rd_tag;
                ototal_next         = alu_res[SEQ_W-1:0];
                olast_next          = (cnt_reg == CNT_W'(1));
                valid_next[ptr_reg] = 1'b0;
                mvalid_next         = 1'b1;
                state_next          = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    mvalid_next  = 1'b0;
                    exp_next     = alu_res[SEQ_W-1:0];
                    exp_idx_next = next_idx(exp_idx_reg);
                    ptr_next     = next_idx(ptr_reg);
                    cnt_next     = cnt_reg - 1'b1;
                    state_next   = olast_reg ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= CFG_W'(16);
            ack_mode_reg    <= 1'b0;
            exp_reg         <= '0;
            exp_idx_reg     <= '0;
            total_reg       <= '0;
            valid_reg       <= '0;
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            mvalid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            exp_reg     <= exp_next;
            exp_idx_reg <= exp_idx_next;
            total_reg   <= total_next;
            valid_reg   <= valid_next;
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            mvalid_reg  <= mvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_WINDOW_SIZE: window_size_reg <= cfg_wdata;
                    REG_ACK_MODE:    ack_mode_reg    <= cfg_wdata[0];
                    default:         ack_mode_reg    <= ack_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            seq_reg <= s_tdata[31:0];
            len_reg <= len_sat;
            tag_reg <= s_tdata[58:43];
        end
        kind_reg   <= kind_next;
        oseq_reg   <= oseq_next;
        olen_reg   <= olen_next;
        otag_reg   <= otag_next;
        ototal_reg <= ototal_next;
        olast_reg  <= olast_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("block not busy after input transfer");

    a_exp_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == KIND_DELIV) |=> exp_reg == $past(exp_reg) + 1'b1)
        else $error("expected sequence did not advance on delivery");

    a_deliv_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DELIV) |-> m_tdata[31:0] == exp_reg)
        else $error("delivery sequence differs from expected");

    a_rel_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(REL_CAP))
        else $error("release count beyond cap");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for reorder_receive_window, directed table then random phases
// depends on rrw_pkg and the reorder_receive_window rtl; carries its own window and byte-total predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrw_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_value;
        logic [LEN_W-1:0]  length;
        logic [TAG_W-1:0]  tag;
        logic [SEQ_W-1:0]  total;
        logic              last;
    } rx_result_t;

    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  win;
        logic              mode;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  tag;
        bit                typed;
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_value;
        logic              last;
    } stim_row_t;

    localparam int NUM_PHASES = 8;
    localparam int PHASE_WIN   [NUM_PHASES] = '{16, 1, 8, 31, 0, 5, 16, 12};
    localparam int PHASE_MODE  [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{55, 45, 50, 45, 10, 45, 35, 35};
    localparam int CALM_PHASE = 2;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [95:0]       m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // predictor state
    logic [SEQ_W-1:0] next_seq        = '0;
    logic [SEQ_W-1:0] delivered_bytes = '0;
    bit               held     [DEF_WINDOW];
    logic [LEN_W-1:0] held_len [DEF_WINDOW];
    logic [TAG_W-1:0] held_tag [DEF_WINDOW];
    logic [CFG_W-1:0] win_reg  = CFG_W'(DEF_WINDOW);
    logic             mode_reg = 1'b0;

    rx_result_t due_results [$];
    stim_row_t  rows [$];
    int         mismatches = 0;
    bit         calm       = 1'b0;
    int         rx_hold    = 0;

    reorder_receive_window u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [CFG_W-1:0] span();
        return (win_reg > CFG_W'(DEF_WINDOW)) ? CFG_W'(DEF_WINDOW) : win_reg;
    endfunction

    // one packet: ack or drop first, then in-order deliveries
    task automatic window_receive(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len_in,
                                  input logic [TAG_W-1:0] tag, output int first);
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  prior_total;
        logic [SEQ_W-1:0]  ack;
        logic [KIND_W-1:0] kind;
        int unsigned       slot;
        int                rel;
        rx_result_t        head;
        rx_result_t        r;
        len         = (len_in > LEN_W'(DEF_MAX_PAYLOAD)) ? LEN_W'(DEF_MAX_PAYLOAD) : len_in;
        prior_total = delivered_bytes;
        kind        = KIND_ACK;
        head        = '{default: '0};
        first       = due_results.size();
        due_results = {due_results, head};
        if ({1'b0, seq} >= {1'b0, next_seq} + {28'b0, span()}) begin
            kind = KIND_DROP;
            ack  = seq;
        end else if (seq < next_seq) begin
            kind = mode_reg ? KIND_ACK : KIND_DROP;
            ack  = seq;
        end else begin
            slot           = seq % DEF_WINDOW;
            held[slot]     = 1'b1;
            held_len[slot] = len;
            held_tag[slot] = tag;
            if (seq == next_seq) begin
                rel = 0;
                while (rel < MAX_REL && held[next_seq % DEF_WINDOW]) begin
                    slot            = next_seq % DEF_WINDOW;
                    delivered_bytes = delivered_bytes + SEQ_W'(held_len[slot]);
                    r.kind          = KIND_DELIV;
                    r.seq_value     = next_seq;
                    r.length        = held_len[slot];
                    r.tag           = held_tag[slot];
                    r.total         = delivered_bytes;
                    r.last          = 1'b0;
                    due_results     = {due_results, r};
                    held[slot] = 1'b0;
                    next_seq   = next_seq + 1;
                    rel++;
                end
            end
            ack = mode_reg ? seq : next_seq;
        end
        head.kind      = kind;
        head.seq_value = ack;
        head.total     = prior_total;
        due_results[first] = head;
        r = due_results[$];
        r.last = 1'b1;
        due_results[$] = r;
    endtask

    function automatic void add_pkt(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                                    input logic [TAG_W-1:0] tag, input bit typed = 1'b0,
                                    input logic [KIND_W-1:0] kind = KIND_ACK,
                                    input logic [SEQ_W-1:0] seq_value = '0,
                                    input logic last = 1'b1);
        stim_row_t row;
        row           = '{default: '0};
        row.seq       = seq;
        row.len       = len;
        row.tag       = tag;
        row.typed     = typed;
        row.kind      = kind;
        row.seq_value = seq_value;
        row.last      = last;
        rows          = {rows, row};
    endfunction

    function automatic void add_cfg(input logic [CFG_W-1:0] win, input logic mode);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.win    = win;
        row.mode   = mode;
        rows       = {rows, row};
    endfunction

    task automatic send_packet(input stim_row_t row);
        int         gap;
        int         first;
        rx_result_t head;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, row.tag, row.len, row.seq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        window_receive(row.seq, row.len, row.tag, first);
        if (row.typed) begin
            head           = due_results[first];
            head.kind      = row.kind;
            head.seq_value = row.seq_value;
            head.last      = row.last;
            due_results[first] = head;
        end
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0 || !s_tready) @(negedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] win, input logic mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_SIZE;
        cfg_wdata <= win;
        @(negedge aclk);
        cfg_index <= REG_ACK_MODE;
        cfg_wdata <= {4'($urandom_range(0, 15)), mode};
        @(negedge aclk);
        cfg_we   <= 1'b0;
        win_reg  = win;
        mode_reg = mode;
    endtask

    task automatic random_phase(input int count);
        int               sent;
        int               n;
        int               k;
        int               j;
        int               lim;
        logic [SEQ_W-1:0] seqs [$];
        logic [SEQ_W-1:0] tmp;
        logic [SEQ_W-1:0] seq;
        stim_row_t        row;
        sent = 0;
        while (sent < count) begin
            seqs = {};
            if ($urandom_range(0, 99) < 65 && span() > 0) begin
                // shuffled run of the next packets, sometimes with a repeat
                n = $urandom_range(1, span());
                for (k = 0; k < n; k++) seqs = {seqs, next_seq + SEQ_W'(k)};
                for (k = n - 1; k > 0; k--) begin
                    j       = $urandom_range(0, k);
                    tmp     = seqs[k];
                    seqs[k] = seqs[j];
                    seqs[j] = tmp;
                end
                if ($urandom_range(0, 3) == 0)
                    seqs.insert($urandom_range(0, n), seqs[$urandom_range(0, n - 1)]);
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        if (next_seq == 0) begin
                            seq = $urandom;
                        end else begin
                            lim = (next_seq > 40) ? 40 : int'(next_seq);
                            seq = next_seq - $urandom_range(1, lim);
                        end
                    end
                    1: seq = next_seq + span() + $urandom_range(0, 64);
                    2: seq = $urandom;
                    3: seq = $urandom_range(0, 1) ? '1 : '0;
                    default: seq = next_seq + $urandom_range(0, span());
                endcase
                seqs = {seqs, seq};
            end
            foreach (seqs[i]) begin
                row     = '{default: '0};
                row.seq = seqs[i];
                row.len = LEN_W'($urandom_range(0, 2047));
                row.tag = TAG_W'($urandom);
                send_packet(row);
                sent++;
            end
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : rx_check
        rx_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            rx_hold = calm ? 0 : $urandom_range(0, 4);
            if (due_results.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual kind %0d seq %0h",
                         $time, m_tuser, m_tdata[31:0]);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(m_tuser));
                compare_field("seq_value", want.seq_value, m_tdata[31:0]);
                compare_field("out_length", 32'(want.length), 32'(m_tdata[42:32]));
                compare_field("out_tag", 32'(want.tag), 32'(m_tdata[58:43]));
                compare_field("total_bytes", want.total, m_tdata[90:59]);
                compare_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        // out of window, far ahead, oversized length, release of two, then a stale repeat
        add_pkt(32'hFFFF_FFFF, 11'd0, 16'h0000, 1'b1, KIND_DROP, 32'hFFFF_FFFF, 1'b1);
        add_pkt(32'd1, 11'd2047, 16'hFFFF, 1'b1, KIND_ACK, 32'd0, 1'b1);
        add_pkt(32'd0, 11'd0, 16'h0000, 1'b1, KIND_ACK, 32'd2, 1'b0);
        add_pkt(32'd0, 11'd5, 16'h0001, 1'b1, KIND_DROP, 32'd0, 1'b1);
        // duplicate ahead packet overwrites its slot
        add_pkt(32'd3, 11'd100, 16'h1234, 1'b1, KIND_ACK, 32'd2, 1'b1);
        add_pkt(32'd3, 11'd200, 16'hABCD, 1'b1, KIND_ACK, 32'd2, 1'b1);
        add_pkt(32'd2, 11'd1472, 16'h5555, 1'b1, KIND_ACK, 32'd4, 1'b0);
        // fill the whole ring backwards, then release all sixteen
        for (int s = 19; s >= 5; s--) add_pkt(32'(s), 11'(s * 97), 16'(s * 4099));
        add_pkt(32'd4, 11'd1473, 16'h0F0F, 1'b1, KIND_ACK, 32'd20, 1'b0);
        add_cfg(5'd16, 1'b1);
        add_pkt(32'd0, 11'd7, 16'h0007, 1'b1, KIND_ACK, 32'd0, 1'b1);
        add_pkt(32'd25, 11'd300, 16'h2525, 1'b1, KIND_ACK, 32'd25, 1'b1);
        add_cfg(5'd0, 1'b0);
        add_pkt(32'd20, 11'd9, 16'h0009, 1'b1, KIND_DROP, 32'd20, 1'b1);
        add_cfg(5'd31, 1'b1);
        add_pkt(32'd35, 11'd2047, 16'h0000, 1'b1, KIND_ACK, 32'd35, 1'b1);
        add_pkt(32'd36, 11'd1, 16'h0001, 1'b1, KIND_DROP, 32'd36, 1'b1);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                set_config(rows[i].win, rows[i].mode);
            else
                send_packet(rows[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(CFG_W'(PHASE_WIN[p]), PHASE_MODE[p][0]);
            calm = (p == CALM_PHASE);
            random_phase(PHASE_ITEMS[p]);
        end

        wait_idle();
        repeat (80) @(negedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/rrw_pkg.sv
sv/rrw_ram.sv
sv/rrw_alu.sv
sv/reorder_receive_window.sv
tb/sv/testbench.sv
